// File: rtl/core/gtpu_pkg.sv
// GTP-U header parser package: payload structs, status codes, helpers.
// No dependencies.
`default_nettype none
package gtpu_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } gtpu_in_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [7:0]  msg_type;
        logic [15:0] declared_length;
        logic [31:0] tunnel_id;
        logic        seq_present;
        logic [15:0] seq_num;
        logic [7:0]  npdu_number;
        logic        ext_flag;
        logic [7:0]  first_ext_type;
        logic [2:0]  ext_count;
        logic [16:0] header_length;
    } gtpu_out_t;

    // Classified byte handed from the front part to the back part
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [16:0] pos;
        logic [16:0] count;
    } gtpu_tok_t;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_SHORT     = 4'd1;
    localparam logic [3:0] ST_BAD_FLAGS = 4'd2;
    localparam logic [3:0] ST_EXT_SHORT = 4'd3;
    localparam logic [3:0] ST_UNCOMP    = 4'd4;
    localparam logic [3:0] ST_E_NO_EXT  = 4'd5;
    localparam logic [3:0] ST_TOO_MANY  = 4'd6;
    localparam logic [3:0] ST_TRUNC     = 4'd7;
    localparam logic [3:0] ST_LEN_MISM  = 4'd8;

    localparam logic [16:0] COUNT_MAX = 17'h1FFFF;
    localparam logic [16:0] BASE_BYTES = 17'd8;
    localparam logic [16:0] EXT_BYTES  = 17'd12;

    function automatic logic type_ok(input logic [7:0] t);
        logic r;
        begin
            if (t == 8'h00 || t == 8'h85 || t == 8'hC0)
                r = 1'b1;
            else if (t == 8'h01 || t == 8'h02 || t == 8'hC1 || t == 8'hC2)
                r = 1'b0;
            else
                r = (t[7:6] < 2'd2);
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/gtpu_front.sv
// GTP-U front part: accepts bytes, tags each with position and saturating count.
// Depends on gtpu_pkg.
`default_nettype none
module gtpu_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gtpu_pkg::gtpu_in_t in_item,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output gtpu_pkg::gtpu_tok_t    tok,
    output logic                   tok_valid,
    input  wire logic              tok_ready
);
    import gtpu_pkg::*;

    logic [16:0] cnt_reg, cnt_next;
    logic [16:0] inc;
    logic        acc;

    assign in_ready = tok_ready;
    assign tok_valid = in_valid;
    assign acc = in_valid && tok_ready;
    assign inc = (cnt_reg < COUNT_MAX) ? cnt_reg + 17'd1 : COUNT_MAX;

    // Tag the byte; count restarts after the last byte
    always_comb
    begin
        tok.data_byte = in_item.data_byte;
        tok.last_byte = in_item.last_byte;
        tok.pos       = cnt_reg;
        tok.count     = inc;
        cnt_next      = cnt_reg;
        if (acc)
            cnt_next = in_item.last_byte ? 17'd0 : inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end
endmodule
`default_nettype wire

// File: rtl/core/gtpu_fifo.sv
// GTP-U queue between front and back parts: small register FIFO.
// Depends on gtpu_pkg.
`default_nettype none
module gtpu_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gtpu_pkg::gtpu_tok_t wr_data,
    input  wire logic              wr_valid,
    output logic                   wr_ready,
    output gtpu_pkg::gtpu_tok_t    rd_data,
    output logic                   rd_valid,
    input  wire logic              rd_ready
);
    import gtpu_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    gtpu_tok_t       mem [DEPTH];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [AW:0]     fill_reg;
    logic            wr, rd;

    assign wr_ready = (fill_reg != (AW+1)'(DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_data  = mem[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wp_reg] <= wr_data;
    end

    // Pointers wrap at the depth
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + AW'(1);
            if (rd)
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + AW'(1);
            fill_reg <= fill_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/gtpu_back.sv
// GTP-U back part: header field state machine and result register.
// Depends on gtpu_pkg.
`default_nettype none
module gtpu_back #(
    parameter int MAX_EXTENSIONS = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire gtpu_pkg::gtpu_tok_t tok,
    input  wire logic               tok_valid,
    output logic                    tok_ready,
    output gtpu_pkg::gtpu_out_t     out_item,
    output logic                    out_valid,
    input  wire logic               out_ready
);
    import gtpu_pkg::*;

    typedef enum logic [2:0] {
        PH_BASE, PH_OPT, PH_EXT_LEN, PH_EXT_BODY, PH_EXT_NEXT, PH_DONE, PH_SKIP
    } phase_t;

    phase_t      ph_reg, ph_next;
    logic [7:0]  flg_reg, flg_next, mt_reg, mt_next, npdu_reg, npdu_next;
    logic [7:0]  nxt_reg, nxt_next;
    logic [15:0] len_reg, len_next, seq_reg, seq_next;
    logic [31:0] teid_reg, teid_next;
    logic [9:0]  left_reg, left_next;
    logic [2:0]  ecnt_reg, ecnt_next;
    logic [3:0]  err_reg, err_next, st;
    logic [16:0] hlen_reg, hlen_next;
    gtpu_out_t   res_reg, res_next;
    logic        ov_reg, acc;
    logic [7:0]  b;
    logic        opt;

    assign tok_ready = !ov_reg || out_ready;
    assign acc = tok_valid && tok_ready;
    assign out_item = res_reg;
    assign out_valid = ov_reg;
    assign b = tok.data_byte;

    // Per-byte field update
    always_comb
    begin
        ph_next = ph_reg; flg_next = flg_reg; mt_next = mt_reg; len_next = len_reg;
        teid_next = teid_reg; seq_next = seq_reg; npdu_next = npdu_reg;
        nxt_next = nxt_reg; left_next = left_reg; ecnt_next = ecnt_reg;
        err_next = err_reg; hlen_next = hlen_reg;
        case (ph_reg)
            PH_BASE:
            begin
                if (tok.pos == 17'd0)
                    flg_next = b;
                else if (tok.pos == 17'd1)
                    mt_next = b;
                else if (tok.pos == 17'd2 || tok.pos == 17'd3)
                    len_next = {len_reg[7:0], b};
                else
                    teid_next = {teid_reg[23:0], b};
                if (tok.pos == 17'd0 && (b[7:5] != 3'd1 || !b[4] || b[0]))
                begin
                    err_next = ST_BAD_FLAGS;
                    ph_next = PH_SKIP;
                end
                else if (tok.pos == 17'd7)
                begin
                    if (flg_reg[2:0] != 3'd0)
                        ph_next = PH_OPT;
                    else
                    begin
                        hlen_next = tok.count;
                        ph_next = PH_DONE;
                    end
                end
            end
            PH_OPT:
            begin
                if (tok.pos == 17'd8 || tok.pos == 17'd9)
                    seq_next = {seq_reg[7:0], b};
                else if (tok.pos == 17'd10)
                    npdu_next = b;
                else
                begin
                    nxt_next = b;
                    if (!type_ok(b))
                    begin
                        err_next = ST_UNCOMP; ph_next = PH_SKIP;
                    end
                    else if (!flg_reg[2])
                    begin
                        hlen_next = tok.count; ph_next = PH_DONE;
                    end
                    else if (b == 8'd0)
                    begin
                        err_next = ST_E_NO_EXT; ph_next = PH_SKIP;
                    end
                    else
                        ph_next = PH_EXT_LEN;
                end
            end
            PH_EXT_LEN:
            begin
                if (b == 8'd0)
                begin
                    err_next = ST_TRUNC; ph_next = PH_SKIP;
                end
                else
                begin
                    left_next = {b, 2'b00} - 10'd2;
                    ph_next = PH_EXT_BODY;
                end
            end
            PH_EXT_BODY:
            begin
                if (left_reg <= 10'd1)
                begin
                    left_next = '0; ph_next = PH_EXT_NEXT;
                end
                else
                    left_next = left_reg - 10'd1;
            end
            PH_EXT_NEXT:
            begin
                if (ecnt_reg >= 3'(MAX_EXTENSIONS))
                begin
                    err_next = ST_TOO_MANY; ph_next = PH_SKIP;
                end
                else
                begin
                    ecnt_next = ecnt_reg + 3'd1;
                    if (b == 8'd0)
                    begin
                        hlen_next = tok.count; ph_next = PH_DONE;
                    end
                    else if (!type_ok(b))
                    begin
                        err_next = ST_UNCOMP; ph_next = PH_SKIP;
                    end
                    else
                        ph_next = PH_EXT_LEN;
                end
            end
            default: ;
        endcase
    end

    // Final status from the post-update state
    always_comb
    begin
        opt = (flg_next[2:0] != 3'd0);
        if (tok.count < BASE_BYTES)
            st = ST_SHORT;
        else if (err_next == ST_BAD_FLAGS)
            st = ST_BAD_FLAGS;
        else if (opt && tok.count < EXT_BYTES)
            st = ST_EXT_SHORT;
        else if (err_next != ST_OK)
            st = err_next;
        else if (ph_next != PH_DONE)
            st = ST_TRUNC;
        else if (17'(len_next) != tok.count - BASE_BYTES)
            st = ST_LEN_MISM;
        else
            st = ST_OK;
        res_next.status          = st;
        res_next.msg_type        = mt_next;
        res_next.declared_length = len_next;
        res_next.tunnel_id       = teid_next;
        res_next.seq_present     = flg_next[1];
        res_next.seq_num         = seq_next;
        res_next.npdu_number     = npdu_next;
        res_next.ext_flag        = flg_next[2];
        res_next.first_ext_type  = nxt_next;
        res_next.ext_count       = ecnt_next;
        res_next.header_length   = (st == ST_OK || st == ST_LEN_MISM) ? hlen_next : '0;
    end

    always_ff @(posedge clk)
    begin
        if (acc && tok.last_byte)
            res_reg <= res_next;
    end

    // Parse state; cleared after the last byte of each packet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg <= PH_BASE; flg_reg <= '0; mt_reg <= '0; len_reg <= '0;
            teid_reg <= '0; seq_reg <= '0; npdu_reg <= '0; nxt_reg <= '0;
            left_reg <= '0; ecnt_reg <= '0; err_reg <= '0; hlen_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (acc && tok.last_byte)
            begin
                ph_reg <= PH_BASE; flg_reg <= '0; mt_reg <= '0; len_reg <= '0;
                teid_reg <= '0; seq_reg <= '0; npdu_reg <= '0; nxt_reg <= '0;
                left_reg <= '0; ecnt_reg <= '0; err_reg <= '0; hlen_reg <= '0;
            end
            else if (acc)
            begin
                ph_reg <= ph_next; flg_reg <= flg_next; mt_reg <= mt_next;
                len_reg <= len_next; teid_reg <= teid_next; seq_reg <= seq_next;
                npdu_reg <= npdu_next; nxt_reg <= nxt_next; left_reg <= left_next;
                ecnt_reg <= ecnt_next; err_reg <= err_next; hlen_reg <= hlen_next;
            end
            if (acc && tok.last_byte)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/gtpu_header_parser_core.sv
// GTP-U v1 header parser top level: front tagger, queue, back parser.
// Depends on gtpu_pkg, gtpu_front, gtpu_fifo, gtpu_back.
//
//   channel | direction | payload     | handshake
//   in      | input     | gtpu_in_t   | in_valid / in_ready
//   out     | output    | gtpu_out_t  | out_valid / out_ready
//
// One byte per cycle sustained while the output is not stalled; the back part's per-byte field update sets it.
// After its last byte is accepted, the byte waits in a queue slot, then the
// back part registers the result as it takes the byte.
// rst_n clears counters, parse state and the queue; no clearing pass.
// Output stalls back up through the two-entry queue to in_ready.
`default_nettype none
module gtpu_header_parser_core #(
    parameter int MAX_EXTENSIONS = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire gtpu_pkg::gtpu_in_t  in_item,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output gtpu_pkg::gtpu_out_t     out_item,
    output logic                    out_valid,
    input  wire logic               out_ready
);
    import gtpu_pkg::*;

    gtpu_tok_t f_tok, q_tok;
    logic      f_valid, f_ready, q_valid, q_ready;

    gtpu_front u_front (
        .clk, .rst_n, .in_item, .in_valid, .in_ready,
        .tok(f_tok), .tok_valid(f_valid), .tok_ready(f_ready)
    );

    gtpu_fifo #(.DEPTH(2)) u_fifo (
        .clk, .rst_n,
        .wr_data(f_tok), .wr_valid(f_valid), .wr_ready(f_ready),
        .rd_data(q_tok), .rd_valid(q_valid), .rd_ready(q_ready)
    );

    gtpu_back #(.MAX_EXTENSIONS(MAX_EXTENSIONS)) u_back (
        .clk, .rst_n, .tok(q_tok), .tok_valid(q_valid), .tok_ready(q_ready),
        .out_item, .out_valid, .out_ready
    );
endmodule
`default_nettype wire

// File: rtl/core/gtpu_checker.sv
// GTP-U parser port checker and its bind to the top level.
// Depends on gtpu_pkg.
`default_nettype none
module gtpu_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire gtpu_pkg::gtpu_in_t in_item,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire gtpu_pkg::gtpu_out_t out_item,
    input wire logic              out_valid,
    input wire logic              out_ready
);
    import gtpu_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    // Status stays in the defined code range
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.status <= ST_LEN_MISM)
        else $error("bad status code");

    // Header length only reported for good or length-mismatch packets
    a_hlen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status != ST_OK && out_item.status != ST_LEN_MISM
        |-> out_item.header_length == '0)
        else $error("header length on error");

    // Input is held off only while a result waits at the output
    a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input blocked with no result pending");
endmodule

bind gtpu_header_parser_core gtpu_checker u_chk (
    .clk, .rst_n, .in_item, .in_valid, .in_ready, .out_item, .out_valid, .out_ready
);
`default_nettype wire
